FILE: rtl/lphs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lphs_pkg
// Shared constants, codes and types of the linear-probe hash set unit.
// ----------------------------------------------------------------------------
package lphs_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int KEY_WIDTH   = 64;

    // Port field widths
    localparam int KEY_IN_W    = 64;
    localparam int KIND_W      = 2;
    localparam int SHIFT_W     = 4;
    localparam int STATUS_W    = 3;
    localparam int SLOT_W      = 10;
    localparam int OUT_DATA_W  = ((SLOT_W + 7) / 8) * 8;

    localparam logic [SHIFT_W-1:0]  SHIFT_RESET = SHIFT_W'(3);
    localparam logic [KEY_IN_W-1:0] KEY_MASK    = {KEY_IN_W{1'b1}} >> (KEY_IN_W - KEY_WIDTH);

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_PRESENT  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FOUND    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_MISSING  = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_ZERO     = 3'd5;
    localparam logic [STATUS_W-1:0] STAT_CLEARED  = 3'd6;

    // Sequencer states
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_PROBE,
        S_CLEAR,
        S_REPLY
    } state_t;

    // Table port request
    typedef struct packed {
        logic                 en;
        logic                 we;
        logic [ADDR_W-1:0]    addr;
        logic [KEY_WIDTH-1:0] wdata;
    } mem_req_t;

    // One result word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } result_t;

endpackage
`default_nettype wire

FILE: rtl/lphs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lphs_ram
// Single-port synchronous RAM, one access per cycle, registered read data
// that holds while the port is not reading.
// ----------------------------------------------------------------------------
module lphs_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write or read, one per cycle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                store_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= store_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: rtl/lphs_probe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lphs_probe
// Probe sequencer: walks the table one slot per cycle from the home slot,
// stores on insert, runs the clearing sweep and holds the pending result.
// ----------------------------------------------------------------------------
module lphs_probe (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [lphs_pkg::KIND_W-1:0]      in_kind,
    input  logic [lphs_pkg::KEY_IN_W-1:0]    in_key,
    input  logic [lphs_pkg::SHIFT_W-1:0]     key_shift,
    output lphs_pkg::mem_req_t               mem_req,
    input  logic [lphs_pkg::KEY_WIDTH-1:0]   mem_rdata,
    output logic                             res_valid,
    input  logic                             res_ready,
    output lphs_pkg::result_t                res
);

    localparam int AW = lphs_pkg::ADDR_W;
    localparam int KW = lphs_pkg::KEY_WIDTH;

    lphs_pkg::state_t state_reg, state_next;

    logic [KW-1:0]                   key_reg, key_next;
    logic                            ins_reg, ins_next;
    logic [AW-1:0]                   addr_reg, addr_next;
    logic [AW-1:0]                   cnt_reg, cnt_next;
    logic [lphs_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [lphs_pkg::SLOT_W-1:0]     slot_reg, slot_next;

    logic [lphs_pkg::KEY_IN_W-1:0]   key_m;
    logic [AW-1:0]                   home;
    logic                            key_zero;
    logic                            is_clear;
    logic                            hit;
    logic                            empty;
    logic                            lap_end;
    logic                            cnt_last;

    // Incoming key and its home slot
    assign key_m    = in_key & lphs_pkg::KEY_MASK;
    assign home     = AW'(key_m >> key_shift);
    assign key_zero = (key_m == '0);
    assign is_clear = (in_kind == lphs_pkg::KIND_CLEAR);

    // Probe outcome on the slot read last cycle
    assign hit      = (mem_rdata == key_reg);
    assign empty    = (mem_rdata == '0);
    assign cnt_last = (cnt_reg == AW'(lphs_pkg::TABLE_DEPTH - 1));
    assign lap_end  = cnt_last;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lphs_pkg::S_INIT;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        ins_reg    <= ins_next;
        addr_reg   <= addr_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lphs_pkg::S_INIT:
            begin
                if (cnt_last)
                begin
                    state_next = lphs_pkg::S_IDLE;
                end
            end
            lphs_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (is_clear)
                    begin
                        state_next = lphs_pkg::S_CLEAR;
                    end
                    else if (key_zero)
                    begin
                        state_next = lphs_pkg::S_REPLY;
                    end
                    else
                    begin
                        state_next = lphs_pkg::S_PROBE;
                    end
                end
            end
            lphs_pkg::S_PROBE:
            begin
                if (hit || empty || lap_end)
                begin
                    state_next = lphs_pkg::S_REPLY;
                end
            end
            lphs_pkg::S_CLEAR:
            begin
                if (cnt_last)
                begin
                    state_next = lphs_pkg::S_REPLY;
                end
            end
            lphs_pkg::S_REPLY:
            begin
                if (res_ready)
                begin
                    state_next = lphs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lphs_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        key_next    = key_reg;
        ins_next    = ins_reg;
        addr_next   = addr_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        slot_next   = slot_reg;
        case (state_reg)
            lphs_pkg::S_INIT, lphs_pkg::S_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            lphs_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next    = key_m[KW-1:0];
                    ins_next    = (in_kind == lphs_pkg::KIND_INSERT);
                    addr_next   = home;
                    cnt_next    = '0;
                    slot_next   = '0;
                    status_next = is_clear ? lphs_pkg::STAT_CLEARED : lphs_pkg::STAT_ZERO;
                end
            end
            lphs_pkg::S_PROBE:
            begin
                if (hit)
                begin
                    status_next = ins_reg ? lphs_pkg::STAT_PRESENT : lphs_pkg::STAT_FOUND;
                    slot_next   = lphs_pkg::SLOT_W'(addr_reg);
                end
                else if (empty)
                begin
                    status_next = ins_reg ? lphs_pkg::STAT_INSERTED : lphs_pkg::STAT_MISSING;
                    slot_next   = ins_reg ? lphs_pkg::SLOT_W'(addr_reg) : '0;
                end
                else if (lap_end)
                begin
                    status_next = ins_reg ? lphs_pkg::STAT_FULL : lphs_pkg::STAT_MISSING;
                    slot_next   = '0;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Outputs: table port, handshakes
    always_comb
    begin
        mem_req   = '0;
        in_ready  = 1'b0;
        res_valid = 1'b0;
        unique case (state_reg)
            lphs_pkg::S_INIT, lphs_pkg::S_CLEAR:
            begin
                mem_req.en   = 1'b1;
                mem_req.we   = 1'b1;
                mem_req.addr = cnt_reg;
            end
            lphs_pkg::S_IDLE:
            begin
                in_ready     = 1'b1;
                mem_req.en   = in_valid && !is_clear && !key_zero;
                mem_req.addr = home;
            end
            lphs_pkg::S_PROBE:
            begin
                if (!hit && empty && ins_reg)
                begin
                    // store into the first empty slot
                    mem_req.en    = 1'b1;
                    mem_req.we    = 1'b1;
                    mem_req.addr  = addr_reg;
                    mem_req.wdata = key_reg;
                end
                else if (!hit && !empty && !lap_end)
                begin
                    // fetch the next slot, wrapping round
                    mem_req.en   = 1'b1;
                    mem_req.addr = addr_reg + 1'b1;
                end
            end
            lphs_pkg::S_REPLY:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign res.status = status_reg;
    assign res.slot   = slot_reg;

endmodule
`default_nettype wire

FILE: rtl/linear_probe_hash_set_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_set_unit
// Hash set of nonzero keys in a single-port table with linear probing.
// ----------------------------------------------------------------------------
// One item is worked at a time. Insert and search probe p slots from the
// home slot, p from 1 to TABLE_DEPTH, before the next word is accepted;
// the single table port reads one slot per cycle, so the probe walk sets
// the time that an item takes. A zero key is answered without a probe, and
// a clear sweeps the whole table one slot per cycle. After reset the same
// sweep runs with s_tready low. A finished result waits in the output
// register while the next word is taken in. key_shift (cfg_data) resets to
// 3; the user must write it only while idle, the block does not enforce it.
// ----------------------------------------------------------------------------
module linear_probe_hash_set_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input words
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lphs_pkg::KEY_IN_W-1:0]       s_tdata,   // [63:0] key
    input  logic [lphs_pkg::KIND_W-1:0]         s_tuser,   // [1:0] kind
    // Result words
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lphs_pkg::OUT_DATA_W-1:0]     m_tdata,   // [9:0] slot, rest zero
    output logic [lphs_pkg::STATUS_W-1:0]       m_tuser,   // [2:0] status
    // Configuration: key_shift
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lphs_pkg::SHIFT_W-1:0]        cfg_data
);

    logic [lphs_pkg::SHIFT_W-1:0]   shift_reg;
    logic                           out_valid_reg;
    lphs_pkg::result_t              out_reg;

    lphs_pkg::mem_req_t             mem_req;
    logic [lphs_pkg::KEY_WIDTH-1:0] mem_rdata;
    logic                           res_valid;
    logic                           res_ready;
    lphs_pkg::result_t              res;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= lphs_pkg::SHIFT_RESET;
        end
        else if (cfg_valid)
        begin
            shift_reg <= cfg_data;
        end
    end

    // Key table
    lphs_ram #(
        .DEPTH (lphs_pkg::TABLE_DEPTH),
        .WIDTH (lphs_pkg::KEY_WIDTH)
    ) u_ram (
        .clk   (clk),
        .en    (mem_req.en),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (mem_rdata)
    );

    // Probe sequencer
    lphs_probe u_probe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_key    (s_tdata),
        .key_shift (shift_reg),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = lphs_pkg::OUT_DATA_W'(out_reg.slot);
    assign m_tuser  = out_reg.status;

endmodule
`default_nettype wire
